// File: rtl/core/lrmp_pkg.sv
// Shared constants for the linear recurrence matrix power block.
package lrmp_pkg;

  localparam int VAL_W         = 30;
  localparam int PROD_W        = 2 * VAL_W;
  localparam int ORDER_W       = 8;
  localparam int DEF_MAX_ORDER = 128;
  localparam int DEF_EXP_BITS  = 60;
  localparam int NUM_BANKS     = 3;
  localparam int FOLD_W        = 27;

  localparam logic [VAL_W-1:0]   MODULUS     = 30'd1000000007;
  // 2^30 mod 1000000007, weight of the bits above VAL_W when folding down
  localparam logic [FOLD_W-1:0]  FOLD_C      = 27'd73741817;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd2;

endpackage

// File: rtl/core/lrmp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module lrmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/linear_recurrence_matrix_power.sv
// Top level: term n of f(i)=f(i-1)+f(i-m) mod 1000000007 by companion-matrix power.
// - Input channel (in_valid/in_stall/in_exponent): one beat carries the
//   exponent n. Only one beat is in work at a time; in_stall stays high from
//   acceptance until the result has been handed to the output register.
// - Output channel (out_valid/out_stall/out_term_value): one beat per input,
//   entry (0,0) of C^n. The output register holds the beat while out_stall is
//   high; the next exponent can be accepted meanwhile, and its result waits
//   in the sequencer until the register frees up.
// - Configuration: cfg_wr_en/cfg_wr_data write the order m; write while idle.
//   Orders below 2 act as 2, above MAX_ORDER as MAX_ORDER.
// - Sequencing: the matrices are built first; then each matrix product runs on
//   one shared 30x30 multiplier, each entry a sum of m products followed by
//   fold-by-2^30 reduction steps. An exponent with b significant bits takes
//   b-1 squarings plus one product per set bit; n = 0 needs only the build.
//   Only one exponent is in work at a time, with no overlap between items.
// - Three RAM banks hold base, accumulator and scratch; roles rotate by
//   pointer swap instead of copying.
// - Reset (synchronous, rst_n low) returns to idle, clears the output valid
//   and sets the order to 2. RAM contents need no clearing.
module linear_recurrence_matrix_power
  import lrmp_pkg::*;
#(
  parameter int MAX_ORDER     = DEF_MAX_ORDER,
  parameter int EXPONENT_BITS = DEF_EXP_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [EXPONENT_BITS-1:0] in_exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VAL_W-1:0]         out_term_value,
  input  logic                     cfg_wr_en,
  input  logic [ORDER_W-1:0]       cfg_wr_data
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_ORDER);
  localparam int SUM_W = PROD_W + IW;
  localparam int HI_W  = SUM_W - VAL_W;
  localparam int FP_W  = HI_W + FOLD_W;
  localparam logic [AW-1:0] STRIDE = AW'(MAX_ORDER);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DEC, S_MAC, S_DRAIN, S_RED, S_WR, S_SQCHK, S_RD, S_OUT
  } state_t;

  state_t                   state_r;
  logic [ORDER_W-1:0]       order_r;
  logic [IW-1:0]            ordm1_r, ordm1;
  logic [EXPONENT_BITS-1:0] exp_r;
  logic [IW-1:0]            row_r, col_r, k_r;
  logic                     op_sq_r;
  logic [1:0]               base_sel_r, acc_sel_r, scr_sel_r;
  logic                     rdv_r, prv_r;
  logic [PROD_W-1:0]        prod_r;
  logic [SUM_W-1:0]         sum_r;
  logic [VAL_W-1:0]         rem_r;
  logic                     out_valid_r;
  logic [VAL_W-1:0]         out_val_r;

  logic [VAL_W-1:0] rd_a [NUM_BANKS];
  logic [VAL_W-1:0] rd_b [NUM_BANKS];
  logic             bank_we [NUM_BANKS];
  logic [VAL_W-1:0] bank_wd [NUM_BANKS];

  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [1:0]       a_sel;
  logic [VAL_W-1:0] a_data, b_data;
  logic             comp_bit, ident_bit;
  logic             col_last, row_last, k_last;
  logic [FP_W-1:0]  fold_prod;
  logic [SUM_W-1:0] fold_sum;
  logic [VAL_W-1:0] sum_lo;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                              input logic [IW-1:0] col);
    return AW'(row) * STRIDE + AW'(col);
  endfunction

  // Clamp the configured order into 2..MAX_ORDER, kept as order minus one.
  always_comb begin
    if (order_r < 8'd2) begin
      ordm1 = IW'(1);
    end else if ({1'b0, order_r} > 9'(MAX_ORDER)) begin
      ordm1 = IW'(MAX_ORDER - 1);
    end else begin
      ordm1 = IW'(order_r - 8'd1);
    end
  end

  assign col_last = (col_r == ordm1_r);
  assign row_last = (row_r == ordm1_r);
  assign k_last   = (k_r == ordm1_r);

  // Companion matrix: ones at row 0 columns 0 and m-1, and on the subdiagonal.
  assign comp_bit  = (row_r == '0) ? ((col_r == '0) || col_last)
                                   : (({1'b0, col_r} + 1'b1) == {1'b0, row_r});
  assign ident_bit = (row_r == col_r);

  assign waddr   = cell_addr(row_r, col_r);
  assign raddr_a = (state_r == S_MAC) ? cell_addr(row_r, k_r) : '0;
  assign raddr_b = cell_addr(k_r, col_r);

  assign a_sel  = (op_sq_r && state_r != S_RD && state_r != S_OUT) ? base_sel_r : acc_sel_r;
  assign a_data = rd_a[a_sel];
  assign b_data = rd_b[base_sel_r];

  // Fold the bits above 2^30 back in with weight 2^30 mod p; each step shrinks the sum.
  assign sum_lo    = sum_r[VAL_W-1:0];
  assign fold_prod = FP_W'(sum_r[SUM_W-1:VAL_W]) * FP_W'(FOLD_C);
  assign fold_sum  = SUM_W'(fold_prod) + SUM_W'(sum_lo);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    always_comb begin
      if (state_r == S_INIT) begin
        bank_we[b] = (2'(b) == base_sel_r) || (2'(b) == acc_sel_r);
        bank_wd[b] = (2'(b) == acc_sel_r) ? VAL_W'(ident_bit) : VAL_W'(comp_bit);
      end else begin
        bank_we[b] = (state_r == S_WR) && (2'(b) == scr_sel_r);
        bank_wd[b] = rem_r;
      end
    end

    lrmp_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk    (clk),
      .we     (bank_we[b]),
      .waddr  (waddr),
      .wdata  (bank_wd[b]),
      .raddr_a(raddr_a),
      .raddr_b(raddr_b),
      .rdata_a(rd_a[b]),
      .rdata_b(rd_b[b])
    );
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_term_value = out_val_r;

  always_ff @(posedge clk) begin
    // Multiply-accumulate pipe: read data, product, sum.
    if (rdv_r) begin
      prod_r <= PROD_W'(a_data) * PROD_W'(b_data);
    end
    if (prv_r) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end

    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RESET;
      out_valid_r <= 1'b0;
      base_sel_r  <= 2'd0;
      acc_sel_r   <= 2'd1;
      scr_sel_r   <= 2'd2;
      op_sq_r     <= 1'b0;
      rdv_r       <= 1'b0;
      prv_r       <= 1'b0;
    end else begin
      rdv_r <= (state_r == S_MAC);
      prv_r <= rdv_r;
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            exp_r   <= in_exponent;
            ordm1_r <= ordm1;
            row_r   <= '0;
            col_r   <= '0;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          if (col_last) begin
            col_r <= '0;
            if (row_last) begin
              state_r <= S_DEC;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        S_DEC: begin
          if (exp_r == '0) begin
            state_r <= S_RD;
          end else if (exp_r[0]) begin
            op_sq_r <= 1'b0;
            row_r   <= '0;
            col_r   <= '0;
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_MAC;
          end else begin
            state_r <= S_SQCHK;
          end
        end
        S_SQCHK: begin
          exp_r <= exp_r >> 1;
          if ((exp_r >> 1) != '0) begin
            op_sq_r <= 1'b1;
            row_r   <= '0;
            col_r   <= '0;
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_MAC;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_MAC: begin
          if (k_last) begin
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait for the last product to land in the sum.
          if (!rdv_r && !prv_r) begin
            state_r <= S_RED;
          end
        end
        S_RED: begin
          // Fold until the sum fits in 30 bits, then one compare and subtract.
          if (sum_r[SUM_W-1:VAL_W] != '0) begin
            sum_r <= fold_sum;
          end else begin
            rem_r   <= (sum_lo >= MODULUS) ? (sum_lo - MODULUS) : sum_lo;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          k_r   <= '0;
          sum_r <= '0;
          if (col_last) begin
            col_r <= '0;
            if (row_last) begin
              // Product done: scratch takes over the destination role.
              if (op_sq_r) begin
                base_sel_r <= scr_sel_r;
                scr_sel_r  <= base_sel_r;
                state_r    <= S_DEC;
              end else begin
                acc_sel_r <= scr_sel_r;
                scr_sel_r <= acc_sel_r;
                state_r   <= S_SQCHK;
              end
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= S_MAC;
            end
          end else begin
            col_r   <= col_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || !out_stall) begin
            out_val_r   <= a_data;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/tb.sv
// Testbench for the linear recurrence matrix power block.
`timescale 1ns / 1ps

module tb;
  import lrmp_pkg::*;

  localparam int EXP_W     = DEF_EXP_BITS;
  localparam int MAX_ORD   = DEF_MAX_ORDER;
  localparam longint unsigned MODV = 64'd1000000007;
  // idle cycles to let the sequencer settle before an order write
  localparam int QUIET_CYCLES = 40;

  typedef enum logic [1:0] {ACT_BEAT, ACT_ORDER, ACT_DRAIN} action_kind_t;

  typedef struct {
    action_kind_t     kind;
    logic [EXP_W-1:0] exponent;
    logic [ORDER_W-1:0] order;
  } action_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [EXP_W-1:0]   in_exponent;
  logic               out_valid;
  logic               out_stall;
  logic [VAL_W-1:0]   out_term_value;
  logic               cfg_wr_en;
  logic [ORDER_W-1:0] cfg_wr_data;

  action_t          pending_actions[$];
  logic [VAL_W-1:0] term_queue[$];
  logic [ORDER_W-1:0] order_shadow;
  int               err_count = 0;
  int               quiet_count;
  int               in_gap;
  int               out_gap;

  linear_recurrence_matrix_power u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_term_value (out_term_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Append to the stimulus plan.
  function automatic void add_action(input action_t a);
    pending_actions = {pending_actions, a};
  endfunction

  // Append to the expected results.
  function automatic void add_term(input logic [VAL_W-1:0] v);
    term_queue = {term_queue, v};
  endfunction

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // a*b over the leading m-by-m block, row-major with stride m.
  function automatic void mat_mul(ref longint unsigned dst[], input longint unsigned a[],
                                  input longint unsigned b[], input int m);
    longint unsigned acc;
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < m; c++) begin
        acc = 0;
        for (int k = 0; k < m; k++) begin
          acc = (acc + a[r*m+k] * b[k*m+c]) % MODV;
        end
        dst[r*m+c] = acc;
      end
    end
  endfunction

  // Entry (0,0) of the companion matrix raised to the exponent, mod 1e9+7.
  function automatic logic [VAL_W-1:0] recurrence_term(input logic [ORDER_W-1:0] order_reg,
                                                        input logic [EXP_W-1:0] n);
    int m;
    logic [EXP_W-1:0] y;
    bit fresh;
    longint unsigned base[];
    longint unsigned acc[];
    longint unsigned tmp[];
    m = order_reg;
    if (m < 2) m = 2;
    if (m > MAX_ORD) m = MAX_ORD;
    base = new[m*m];
    acc  = new[m*m];
    tmp  = new[m*m];
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < m; c++) begin
        base[r*m+c] = ((r == 0 && (c == 0 || c == m-1)) || (r > 0 && c + 1 == r)) ? 1 : 0;
        acc[r*m+c]  = (r == c) ? 1 : 0;
      end
    end
    y = n;
    fresh = 1'b1;
    while (y != 0) begin
      if (y[0]) begin
        if (fresh) begin
          acc = base;
          fresh = 1'b0;
        end else begin
          mat_mul(tmp, acc, base, m);
          acc = tmp;
        end
      end
      y = y >> 1;
      if (y != 0) begin
        mat_mul(tmp, base, base, m);
        base = tmp;
      end
    end
    return acc[0][VAL_W-1:0];
  endfunction

  function automatic action_t beat(input logic [EXP_W-1:0] n);
    action_t a;
    a.kind = ACT_BEAT;
    a.exponent = n;
    a.order = '0;
    return a;
  endfunction

  function automatic action_t set_order(input logic [ORDER_W-1:0] m);
    action_t a;
    a.kind = ACT_ORDER;
    a.exponent = '0;
    a.order = m;
    return a;
  endfunction

  // Driver: one beat in flight at a time, order writes only once drained.
  always @(posedge clk) begin
    action_t head;
    bit      nv;
    bit      nw;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_exponent  <= '0;
      cfg_wr_en    <= 1'b0;
      cfg_wr_data  <= '0;
      order_shadow <= ORDER_RESET;
      quiet_count  <= 0;
      in_gap       <= 0;
    end else begin
      nv = in_valid;
      nw = 1'b0;
      quiet_count <= (term_queue.size() == 0 && !in_valid) ? quiet_count + 1 : 0;
      if (in_valid && !in_stall) begin
        // predict at acceptance with the order in force now
        add_term(recurrence_term(order_shadow, in_exponent));
        nv = 1'b0;
      end
      if (!(in_valid && in_stall) && !nv && !cfg_wr_en) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_actions.size() != 0) begin
          head = pending_actions[0];
          case (head.kind)
            ACT_BEAT: begin
              void'(pending_actions.pop_front());
              nv = 1'b1;
              in_exponent <= head.exponent;
              in_gap <= draw_gap();
            end
            ACT_ORDER: begin
              if (term_queue.size() == 0 && !in_valid && quiet_count >= QUIET_CYCLES) begin
                void'(pending_actions.pop_front());
                nw = 1'b1;
                cfg_wr_data  <= head.order;
                order_shadow <= head.order;
              end
            end
            default: begin
              // hold off the sender until every result is back
              if (term_queue.size() == 0 && !in_valid)
                void'(pending_actions.pop_front());
            end
          endcase
        end
      end
      in_valid  <= nv;
      cfg_wr_en <= nw;
    end
  end

  // Monitor: random stall on the result side, compare each accepted beat.
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (term_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected term %0d", out_term_value));
        end else begin
          want = term_queue.pop_front();
          if (out_term_value !== want)
            report_mismatch($sformatf("term_value got %0d want %0d", out_term_value, want));
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap   <= draw_gap();
      end
    end
  end

  // Stimulus plan, then wait for the last result.
  initial begin
    logic [EXP_W-1:0] n;
    logic [ORDER_W-1:0] m;
    int bits;
    rst_n = 1'b0;

    // directed: exponent extremes at the reset order
    add_action(beat('0));
    add_action(beat(60'd1));
    add_action(beat(60'd2));
    add_action(beat(60'd10));
    add_action(beat({EXP_W{1'b1}}));
    add_action(beat(60'h800000000000000));
    add_action(beat(60'hAAAAAAAAAAAAAAA));
    add_action(beat(60'h555555555555555));
    add_action('{ACT_DRAIN, '0, '0});
    // orders below two act as two
    add_action(set_order(8'd0));
    add_action(beat(60'd5));
    add_action(set_order(8'd1));
    add_action(beat(60'd7));
    add_action(set_order(8'd3));
    add_action(beat('0));
    add_action(beat(60'd1));
    add_action(beat(60'd20));
    add_action(beat(60'd1000));
    add_action(set_order(8'd16));
    add_action(beat(60'd5));
    // order above the maximum clamps; keep large orders to cheap exponents
    add_action(set_order(8'd255));
    add_action(beat('0));
    add_action(beat(60'd1));
    add_action(set_order(8'd128));
    add_action(beat(60'd1));

    // random: small orders, mostly short exponents, a few full width
    for (int blk = 0; blk < 5; blk++) begin
      m = ORDER_W'($urandom_range(6, 2));
      add_action(set_order(m));
      for (int i = 0; i < 16; i++) begin
        if (m <= 3 && $urandom_range(9) == 0) bits = EXP_W;
        else bits = $urandom_range((m <= 3) ? 16 : 10, 1);
        n = EXP_W'({$urandom(), $urandom()});
        n = n & ((60'd1 << bits) - 60'd1);
        add_action(beat(n));
        if (i == 10 && blk == 2) add_action('{ACT_DRAIN, '0, '0});
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_actions.size() == 0 && !in_valid && term_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (err_count == 0 && term_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #500_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
